@@ rtl/dlfp_pkg.sv @@
// ----------------------------------------------------------------------------
// dlfp_pkg
// Types, constants and lookup functions shared by the dive log parser.
// ----------------------------------------------------------------------------
package dlfp_pkg;

    localparam int CountBitsDef = 16;
    localparam int EventDataBytes = 4;
    localparam int MaxRes = 4;

    localparam logic [3:0] KindHeader = 4'd0;
    localparam logic [3:0] KindDepth  = 4'd1;
    localparam logic [3:0] KindTemp   = 4'd2;
    localparam logic [3:0] KindTank   = 4'd3;
    localparam logic [3:0] KindEvent  = 4'd4;
    localparam logic [3:0] KindAscent = 4'd5;
    localparam logic [3:0] KindGas    = 4'd6;
    localparam logic [3:0] KindStop   = 4'd7;
    localparam logic [3:0] KindDeco   = 4'd8;

    localparam logic [1:0] RegStartDepth = 2'd0;
    localparam logic [1:0] RegStartTemp  = 2'd1;
    localparam logic [1:0] RegStartTank  = 2'd2;
    localparam logic [1:0] RegInterval   = 2'd3;

    localparam logic [7:0] CodeDecoDeeper  = 8'hAB;
    localparam logic [7:0] CodeDecoShallow = 8'hAD;
    localparam logic [7:0] CodeNotHeader   = 8'h40;
    localparam logic [4:0] EvtUnknown      = 5'd29;
    localparam logic [7:0] TempOffset      = 8'd40;
    localparam logic [15:0] CeilStep       = 16'd10;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_FIRST,
        PH_SECOND,
        PH_DATA
    } t_phase;

    typedef struct packed {
        logic [3:0]         kind;
        logic signed [31:0] value;
        logic [15:0]        ceil;
        logic [4:0]         idx;
        logic               pre;
    } t_res;

    typedef struct packed {
        logic [1:0]        nm1;
        t_res [MaxRes-1:0] res;
    } t_job;

    function automatic logic [4:0] record_extra(input logic [7:0] code);
        logic [4:0] r;
        unique case (code)
            8'h00, 8'h03: r = 5'd16;
            8'h01, 8'h10: r = 5'd20;
            8'h02:        r = 5'd17;
            8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
            8'h0B, 8'h0C, 8'h0D, 8'h0E: r = 5'd18;
            default:      r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] event_index(input logic [7:0] code);
        logic [4:0] r;
        unique case (code)
            8'hA8: r = 5'd0;
            8'hA9: r = 5'd1;
            8'hAB: r = 5'd2;
            8'hAD: r = 5'd3;
            8'hBD: r = 5'd4;
            8'hC0: r = 5'd5;
            8'hC1: r = 5'd6;
            8'hC2: r = 5'd7;
            8'hC3: r = 5'd8;
            8'hC4: r = 5'd9;
            8'hC5: r = 5'd10;
            8'hC7: r = 5'd11;
            8'hC8: r = 5'd12;
            8'hCC: r = 5'd13;
            8'hCE: r = 5'd14;
            8'hCD: r = 5'd15;
            8'hD0: r = 5'd16;
            8'hD3: r = 5'd17;
            8'hD6: r = 5'd18;
            8'hD8: r = 5'd19;
            8'hE1: r = 5'd20;
            8'hE2: r = 5'd21;
            8'hE3: r = 5'd22;
            8'hE5: r = 5'd23;
            8'hEE: r = 5'd24;
            8'hEF: r = 5'd25;
            8'hF0: r = 5'd26;
            8'hF3: r = 5'd27;
            8'hF6: r = 5'd28;
            default: r = EvtUnknown;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/dlfp_front.sv @@
// ----------------------------------------------------------------------------
// dlfp_front
// Parses each accepted log byte, updates the accumulators and builds a job.
// ----------------------------------------------------------------------------
module dlfp_front #(
    parameter int COUNT_BITS = dlfp_pkg::CountBitsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_start_of_log,
    input  logic                  i_end_of_log,
    input  logic [11:0]           i_start_depth,
    input  logic [8:0]            i_start_temp,
    input  logic [14:0]           i_start_tank,
    output logic                  o_push,
    output dlfp_pkg::t_job        o_job,
    output logic [COUNT_BITS-1:0] o_count
);

    dlfp_pkg::t_phase         r_phase, n_phase, s_phase, fb_phase;
    logic [4:0]               r_hleft, n_hleft, s_hleft;
    logic signed [15:0]       r_depth, n_depth, s_depth, fb_depth;
    logic signed [19:0]       r_tank, n_tank, s_tank;
    logic signed [15:0]       r_gas, n_gas, s_gas;
    logic [15:0]              r_ceil, n_ceil, s_ceil, fb_ceil;
    logic [COUNT_BITS-1:0]    r_count, n_count, s_count, fb_count;
    logic [31:0]              r_edata, n_edata;
    logic [2:0]               r_ebl, n_ebl, s_ebl, fb_ebl;
    dlfp_pkg::t_res           fb_res, init_d, init_t, init_k, hdr_res;
    logic                     fb_pre;
    logic [2:0]               cnt;
    logic [6:0]               mag7;
    logic signed [16:0]       sum16;
    logic signed [20:0]       sum20;
    logic signed [7:0]        dd;
    logic [1:0]               rot;

    function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
        logic signed [15:0] r;
        if (v > 17'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -17'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    always_comb begin
        if (i_start_of_log) begin
            s_phase = dlfp_pkg::PH_HEADER;
            s_hleft = '0;
            s_depth = 16'(i_start_depth);
            s_tank  = 20'(i_start_tank);
            s_gas   = '0;
            s_ceil  = '0;
            s_count = '0;
            s_ebl   = '0;
        end else begin
            s_phase = r_phase;
            s_hleft = r_hleft;
            s_depth = r_depth;
            s_tank  = r_tank;
            s_gas   = r_gas;
            s_ceil  = r_ceil;
            s_count = r_count;
            s_ebl   = r_ebl;
        end

        fb_res   = '0;
        fb_phase = s_phase;
        fb_depth = s_depth;
        fb_ceil  = s_ceil;
        fb_count = s_count;
        fb_ebl   = s_ebl;
        fb_pre   = 1'b0;
        dd       = i_data_byte[6] ? -8'(i_data_byte[5:0]) : 8'(i_data_byte[5:0]);
        if (i_data_byte[7]) begin
            fb_res.kind  = dlfp_pkg::KindEvent;
            fb_res.value = 32'(i_data_byte);
            fb_res.idx   = dlfp_pkg::event_index(i_data_byte);
            fb_phase     = dlfp_pkg::PH_FIRST;
            if (i_data_byte == dlfp_pkg::CodeDecoDeeper) begin
                fb_ceil  = s_ceil + dlfp_pkg::CeilStep;
                fb_ebl   = 3'(dlfp_pkg::EventDataBytes);
                fb_phase = dlfp_pkg::PH_DATA;
            end else if (i_data_byte == dlfp_pkg::CodeDecoShallow) begin
                fb_ceil  = s_ceil - dlfp_pkg::CeilStep;
                fb_ebl   = 3'(dlfp_pkg::EventDataBytes);
                fb_phase = dlfp_pkg::PH_DATA;
            end
        end else begin
            fb_count     = s_count + 1'b1;
            fb_depth     = sat16(17'(s_depth) + 17'(dd));
            fb_res.kind  = dlfp_pkg::KindDepth;
            fb_res.value = 32'(fb_depth);
            fb_phase     = dlfp_pkg::PH_SECOND;
            fb_pre       = 1'b1;
        end

        init_d       = '0;
        init_d.kind  = dlfp_pkg::KindDepth;
        init_d.value = 32'(s_depth);
        init_t       = '0;
        init_t.kind  = dlfp_pkg::KindTemp;
        init_t.value = 32'(i_start_temp);
        init_k       = '0;
        init_k.kind  = dlfp_pkg::KindTank;
        init_k.value = 32'(s_tank);
        hdr_res       = '0;
        hdr_res.kind  = dlfp_pkg::KindHeader;
        hdr_res.value = 32'(i_data_byte);

        n_phase = s_phase;
        n_hleft = s_hleft;
        n_depth = s_depth;
        n_tank  = s_tank;
        n_gas   = s_gas;
        n_ceil  = s_ceil;
        n_count = s_count;
        n_ebl   = s_ebl;
        n_edata = r_edata;
        o_job   = '0;
        cnt     = '0;
        mag7    = i_data_byte[6:0];
        rot     = 2'(s_count - 1'b1);
        sum16   = '0;
        sum20   = '0;

        unique case (s_phase)
            dlfp_pkg::PH_FIRST: begin
                o_job.res[0] = fb_res;
                cnt     = 3'd1;
                n_phase = fb_phase;
                n_depth = fb_depth;
                n_ceil  = fb_ceil;
                n_count = fb_count;
                n_ebl   = fb_ebl;
            end
            dlfp_pkg::PH_SECOND: begin
                cnt     = 3'd1;
                n_phase = dlfp_pkg::PH_FIRST;
                unique case (rot)
                    2'd0: begin
                        o_job.res[0].kind  = dlfp_pkg::KindAscent;
                        o_job.res[0].value = i_data_byte[7] ? 32'(mag7) : -32'(mag7);
                    end
                    2'd1: begin
                        sum16 = i_data_byte[7] ? 17'(s_gas) - 17'(mag7)
                                               : 17'(s_gas) + 17'(mag7);
                        n_gas = sat16(sum16);
                        o_job.res[0].kind  = dlfp_pkg::KindGas;
                        o_job.res[0].value = 32'(n_gas);
                    end
                    2'd2: begin
                        sum20 = i_data_byte[7] ? 21'(s_tank) - 21'(mag7)
                                               : 21'(s_tank) + 21'(mag7);
                        if (sum20 > 21'sd524287) begin
                            n_tank = 20'sh7FFFF;
                        end else if (sum20 < -21'sd524288) begin
                            n_tank = 20'sh80000;
                        end else begin
                            n_tank = sum20[19:0];
                        end
                        o_job.res[0].kind  = dlfp_pkg::KindTank;
                        o_job.res[0].value = 32'(n_tank);
                    end
                    default: begin
                        o_job.res[0].kind  = dlfp_pkg::KindTemp;
                        o_job.res[0].value = 32'(mag7) + 32'(dlfp_pkg::TempOffset);
                    end
                endcase
            end
            dlfp_pkg::PH_DATA: begin
                n_edata = {i_data_byte, r_edata[31:8]};
                if (s_ebl != 3'd0) begin
                    n_ebl = s_ebl - 1'b1;
                end
                if (n_ebl == 3'd0) begin
                    cnt = 3'd2;
                    o_job.res[0].kind  = dlfp_pkg::KindStop;
                    o_job.res[0].value = 32'(n_edata[15:0]) + 32'd1;
                    o_job.res[0].ceil  = s_ceil;
                    o_job.res[1].kind  = dlfp_pkg::KindDeco;
                    o_job.res[1].value = 32'(n_edata[31:16]) + 32'd1;
                    n_phase = dlfp_pkg::PH_FIRST;
                end
            end
            default: begin
                if (s_hleft != 5'd0) begin
                    o_job.res[0] = hdr_res;
                    cnt     = 3'd1;
                    n_hleft = s_hleft - 1'b1;
                end else if (!i_data_byte[7] && i_data_byte != dlfp_pkg::CodeNotHeader) begin
                    o_job.res[0] = hdr_res;
                    cnt     = 3'd1;
                    n_hleft = dlfp_pkg::record_extra(i_data_byte);
                end else begin
                    o_job.res[0]     = init_d;
                    o_job.res[1]     = init_t;
                    o_job.res[2]     = init_k;
                    o_job.res[0].pre = fb_pre;
                    o_job.res[1].pre = fb_pre;
                    o_job.res[2].pre = fb_pre;
                    o_job.res[3]     = fb_res;
                    cnt     = 3'd4;
                    n_hleft = '0;
                    n_phase = fb_phase;
                    n_depth = fb_depth;
                    n_ceil  = fb_ceil;
                    n_count = fb_count;
                    n_ebl   = fb_ebl;
                end
                if (i_end_of_log && n_phase == dlfp_pkg::PH_HEADER) begin
                    o_job.res[1] = init_d;
                    o_job.res[2] = init_t;
                    o_job.res[3] = init_k;
                    cnt     = 3'd4;
                    n_hleft = '0;
                    n_phase = dlfp_pkg::PH_FIRST;
                end
            end
        endcase

        o_job.nm1 = 2'(cnt - 3'd1);
        o_count   = n_count;
        o_push    = i_accept && (cnt != 3'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dlfp_pkg::PH_HEADER;
            r_hleft <= '0;
            r_depth <= '0;
            r_tank  <= '0;
            r_gas   <= '0;
            r_ceil  <= '0;
            r_count <= '0;
            r_ebl   <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hleft <= n_hleft;
            r_depth <= n_depth;
            r_tank  <= n_tank;
            r_gas   <= n_gas;
            r_ceil  <= n_ceil;
            r_count <= n_count;
            r_ebl   <= n_ebl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_edata <= n_edata;
        end
    end

endmodule

@@ rtl/dlfp_jobq.sv @@
// ----------------------------------------------------------------------------
// dlfp_jobq
// Two-entry queue of parsed jobs between the front and back parts.
// ----------------------------------------------------------------------------
module dlfp_jobq #(
    parameter int COUNT_BITS = dlfp_pkg::CountBitsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  dlfp_pkg::t_job        i_job,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic                  i_pop,
    output logic                  o_full,
    output logic                  o_valid,
    output dlfp_pkg::t_job        o_job,
    output logic [COUNT_BITS-1:0] o_count
);

    dlfp_pkg::t_job        r_job [2];
    logic [COUNT_BITS-1:0] r_cnt_val [2];
    logic                  r_wp, r_rp;
    logic [1:0]            r_used;

    assign o_full  = (r_used == 2'd2);
    assign o_valid = (r_used != 2'd0);
    assign o_job   = r_job[r_rp];
    assign o_count = r_cnt_val[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_used <= '0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_used <= r_used + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_job[r_wp]     <= i_job;
            r_cnt_val[r_wp] <= i_count;
        end
    end

endmodule

@@ rtl/dlfp_back.sv @@
// ----------------------------------------------------------------------------
// dlfp_back
// Walks head-job results into the output register, one per cycle unless held.
// ----------------------------------------------------------------------------
module dlfp_back #(
    parameter int COUNT_BITS = dlfp_pkg::CountBitsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_job_valid,
    input  dlfp_pkg::t_job        i_job,
    input  logic [COUNT_BITS-1:0] i_count,
    input  logic [7:0]            i_interval,
    output logic                  o_job_pop,
    input  logic                  i_pop,
    output logic                  o_empty,
    output logic [3:0]            o_result_kind,
    output logic [23:0]           o_time_seconds,
    output logic signed [31:0]    o_value,
    output logic signed [15:0]    o_ceiling_feet,
    output logic [4:0]            o_event_index,
    output logic                  o_last_of_run
);

    logic [1:0]              r_k;
    logic                    r_ov;
    logic                    load, last;
    dlfp_pkg::t_res          cur;
    logic [COUNT_BITS-1:0]   cnt_eff;
    logic [COUNT_BITS+7:0]   prod;
    logic [31:0]             p32;
    logic [23:0]             tsat;

    always_comb begin
        cur     = i_job.res[r_k];
        last    = (r_k == i_job.nm1);
        load    = i_job_valid && (!r_ov || i_pop);
        cnt_eff = cur.pre ? i_count - 1'b1 : i_count;
        prod    = COUNT_BITS'(cnt_eff) * (COUNT_BITS+8)'(i_interval);
        p32     = 32'(prod);
        tsat    = (p32 > 32'hFFFFFF) ? 24'hFFFFFF : p32[23:0];
        o_job_pop = load && last;
        o_empty   = !r_ov;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_k  <= '0;
        end else begin
            if (load) begin
                r_ov <= 1'b1;
                r_k  <= last ? 2'd0 : r_k + 1'b1;
            end else if (i_pop) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_result_kind  <= cur.kind;
            o_time_seconds <= tsat;
            o_value        <= cur.value;
            o_ceiling_feet <= cur.ceil;
            o_event_index  <= cur.idx;
            o_last_of_run  <= last;
        end
    end

endmodule

@@ rtl/dive_log_four_phase_parser_top.sv @@
// ----------------------------------------------------------------------------
// dive_log_four_phase_parser_top
// Byte-wise dive log parser with a queue-style input and result channel.
// ----------------------------------------------------------------------------
// Input channel: drive i_data_byte with its start/end flags and raise i_push;
// a byte is taken on a clock edge with i_push high and o_full low.
// Result channel: while o_empty is low the oldest result sits on the o_
// ports; i_pop high takes it on that edge. o_last_of_run marks the final
// result caused by one byte.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx at once.
// A taken byte's job enters the job queue; its results leave through the
// output register. Throughput: one byte per cycle while o_full is low, one
// result per cycle while i_pop is high; a byte makes at most 4 results, and
// a two-entry job queue lets the parser keep taking bytes meanwhile.
// Reset: parser state, queue and output register clear; registers return to
// depth 0, temperature 140, tank 0, interval 1.
// Stall: with i_pop low the output holds, the job queue fills, then o_full
// rises until results drain.
// ----------------------------------------------------------------------------
module dive_log_four_phase_parser_top #(
    parameter int COUNT_BITS = dlfp_pkg::CountBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_start_of_log,
    input  logic               i_end_of_log,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [3:0]         o_result_kind,
    output logic [23:0]        o_time_seconds,
    output logic signed [31:0] o_value,
    output logic signed [15:0] o_ceiling_feet,
    output logic [4:0]         o_event_index,
    output logic               o_last_of_run,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [14:0]        i_cfg_data
);

    logic [11:0]           r_start_depth;
    logic [8:0]            r_start_temp;
    logic [14:0]           r_start_tank;
    logic [7:0]            r_interval;
    logic                  accept, f_push, q_valid, q_pop;
    dlfp_pkg::t_job        f_job, q_job;
    logic [COUNT_BITS-1:0] f_count, q_count;

    assign accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_depth <= '0;
            r_start_temp  <= 9'd140;
            r_start_tank  <= '0;
            r_interval    <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dlfp_pkg::RegStartDepth: r_start_depth <= i_cfg_data[11:0];
                dlfp_pkg::RegStartTemp:  r_start_temp  <= i_cfg_data[8:0];
                dlfp_pkg::RegStartTank:  r_start_tank  <= i_cfg_data;
                default:                 r_interval    <= i_cfg_data[7:0];
            endcase
        end
    end

    dlfp_front #(.COUNT_BITS(COUNT_BITS)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_data_byte    (i_data_byte),
        .i_start_of_log (i_start_of_log),
        .i_end_of_log   (i_end_of_log),
        .i_start_depth  (r_start_depth),
        .i_start_temp   (r_start_temp),
        .i_start_tank   (r_start_tank),
        .o_push         (f_push),
        .o_job          (f_job),
        .o_count        (f_count)
    );

    dlfp_jobq #(.COUNT_BITS(COUNT_BITS)) u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_job   (f_job),
        .i_count (f_count),
        .i_pop   (q_pop),
        .o_full  (o_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_count (q_count)
    );

    dlfp_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job_valid    (q_valid),
        .i_job          (q_job),
        .i_count        (q_count),
        .i_interval     (r_interval),
        .o_job_pop      (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_result_kind  (o_result_kind),
        .o_time_seconds (o_time_seconds),
        .o_value        (o_value),
        .o_ceiling_feet (o_ceiling_feet),
        .o_event_index  (o_event_index),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

@@ bench/dlfp_result_checker.sv @@
// ----------------------------------------------------------------------------
// dlfp_result_checker
// Tracks accepted log bytes and register writes, predicts the parsed dive
// records and compares every popped result field by field, in order.
// ----------------------------------------------------------------------------
module dlfp_result_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic               i_full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_start_of_log,
    input  logic               i_end_of_log,
    input  logic               i_empty,
    input  logic               i_pop,
    input  logic [3:0]         i_result_kind,
    input  logic [23:0]        i_time_seconds,
    input  logic signed [31:0] i_value,
    input  logic signed [15:0] i_ceiling_feet,
    input  logic [4:0]         i_event_index,
    input  logic               i_last_of_run,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [14:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [3:0]         kind;
        logic [23:0]        tsec;
        logic signed [31:0] val;
        logic signed [15:0] ceil;
        logic [4:0]         idx;
        logic               last;
    } t_dive_rec;

    localparam logic [7:0] EVT_TABLE [29] = '{
        8'hA8, 8'hA9, 8'hAB, 8'hAD, 8'hBD, 8'hC0, 8'hC1, 8'hC2, 8'hC3, 8'hC4,
        8'hC5, 8'hC7, 8'hC8, 8'hCC, 8'hCE, 8'hCD, 8'hD0, 8'hD3, 8'hD6, 8'hD8,
        8'hE1, 8'hE2, 8'hE3, 8'hE5, 8'hEE, 8'hEF, 8'hF0, 8'hF3, 8'hF6
    };

    t_dive_rec   want_q[$];
    int          errors;

    logic [11:0] cfg_depth;
    logic [8:0]  cfg_temp;
    logic [14:0] cfg_tank;
    logic [7:0]  cfg_interval;

    dlfp_pkg::t_phase phase;
    int          hdr_left;
    int          depth_acc;
    int          tank_acc;
    int          gas_acc;
    logic [15:0] ceiling;
    logic [15:0] samples;
    logic [31:0] deco_bytes;
    int          deco_left;

    function automatic int clamp(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int record_tail(logic [7:0] code);
        case (code)
            8'h00, 8'h03: return 16;
            8'h01, 8'h10: return 20;
            8'h02:        return 17;
            8'h06, 8'h07, 8'h08, 8'h09, 8'h0A,
            8'h0B, 8'h0C, 8'h0D, 8'h0E: return 18;
            default:      return 0;
        endcase
    endfunction

    function automatic logic [4:0] event_slot(logic [7:0] code);
        for (int i = 0; i < 29; i++) begin
            if (EVT_TABLE[i] == code) return 5'(i);
        end
        return dlfp_pkg::EvtUnknown;
    endfunction

    task automatic add_rec(logic [3:0] kind, int val, logic [15:0] ceil, logic [4:0] idx);
        t_dive_rec   r;
        longint      t;
        t = longint'(samples) * longint'(cfg_interval);
        r.kind = kind;
        r.tsec = t > 64'hFFFFFF ? 24'hFFFFFF : t[23:0];
        r.val  = val;
        r.ceil = ceil;
        r.idx  = idx;
        r.last = 1'b0;
        want_q.push_back(r);
    endtask

    task automatic restart_log();
        phase      = dlfp_pkg::PH_HEADER;
        hdr_left   = 0;
        depth_acc  = int'(cfg_depth);
        tank_acc   = int'(cfg_tank);
        gas_acc    = 0;
        ceiling    = '0;
        samples    = '0;
        deco_bytes = '0;
        deco_left  = 0;
    endtask

    task automatic open_samples();
        add_rec(dlfp_pkg::KindDepth, depth_acc, '0, '0);
        add_rec(dlfp_pkg::KindTemp, int'(cfg_temp), '0, '0);
        add_rec(dlfp_pkg::KindTank, tank_acc, '0, '0);
        phase    = dlfp_pkg::PH_FIRST;
        hdr_left = 0;
    endtask

    task automatic sample_head(logic [7:0] b);
        int mag;
        if (b[7]) begin
            add_rec(dlfp_pkg::KindEvent, int'(b), '0, event_slot(b));
            if (b == dlfp_pkg::CodeDecoDeeper || b == dlfp_pkg::CodeDecoShallow) begin
                ceiling   = b == dlfp_pkg::CodeDecoDeeper ? ceiling + dlfp_pkg::CeilStep
                                                          : ceiling - dlfp_pkg::CeilStep;
                deco_left = dlfp_pkg::EventDataBytes;
                phase     = dlfp_pkg::PH_DATA;
            end
        end else begin
            mag       = int'(b[5:0]);
            samples   = samples + 16'd1;
            depth_acc = clamp(depth_acc + (b[6] ? -mag : mag), -32768, 32767);
            add_rec(dlfp_pkg::KindDepth, depth_acc, '0, '0);
            phase = dlfp_pkg::PH_SECOND;
        end
    endtask

    task automatic parse_byte(logic [7:0] b, logic sol, logic eol);
        int          mark;
        int          mag;
        logic [15:0] slot;
        mark = want_q.size();
        if (sol) restart_log();
        case (phase)
            dlfp_pkg::PH_FIRST: sample_head(b);
            dlfp_pkg::PH_SECOND: begin
                mag  = int'(b[6:0]);
                slot = samples - 16'd1;
                case (slot[1:0])
                    2'd0: add_rec(dlfp_pkg::KindAscent, b[7] ? mag : -mag, '0, '0);
                    2'd1: begin
                        gas_acc = clamp(gas_acc + (b[7] ? -mag : mag), -32768, 32767);
                        add_rec(dlfp_pkg::KindGas, gas_acc, '0, '0);
                    end
                    2'd2: begin
                        tank_acc = clamp(tank_acc + (b[7] ? -mag : mag), -524288, 524287);
                        add_rec(dlfp_pkg::KindTank, tank_acc, '0, '0);
                    end
                    default: add_rec(dlfp_pkg::KindTemp, mag + int'(dlfp_pkg::TempOffset),
                                     '0, '0);
                endcase
                phase = dlfp_pkg::PH_FIRST;
            end
            dlfp_pkg::PH_DATA: begin
                deco_bytes = {b, deco_bytes[31:8]};
                if (deco_left > 0) deco_left--;
                if (deco_left == 0) begin
                    add_rec(dlfp_pkg::KindStop, int'(deco_bytes[15:0]) + 1, ceiling, '0);
                    add_rec(dlfp_pkg::KindDeco, int'(deco_bytes[31:16]) + 1, '0, '0);
                    phase = dlfp_pkg::PH_FIRST;
                end
            end
            default: begin
                if (hdr_left > 0) begin
                    hdr_left--;
                    add_rec(dlfp_pkg::KindHeader, int'(b), '0, '0);
                end else if (!b[7] && b != dlfp_pkg::CodeNotHeader) begin
                    hdr_left = record_tail(b);
                    add_rec(dlfp_pkg::KindHeader, int'(b), '0, '0);
                end else begin
                    open_samples();
                    sample_head(b);
                end
                if (eol && phase == dlfp_pkg::PH_HEADER) open_samples();
            end
        endcase
        if (want_q.size() > mark) want_q[want_q.size() - 1].last = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_dive_rec got;
        t_dive_rec want;
        if (!i_rst_n) begin
            want_q.delete();
            errors       = 0;
            cfg_depth    = '0;
            cfg_temp     = 9'd140;
            cfg_tank     = '0;
            cfg_interval = 8'd1;
            restart_log();
        end else begin
            if (i_pop && !i_empty) begin
                got = '{i_result_kind, i_time_seconds, i_value, i_ceiling_feet,
                        i_event_index, i_last_of_run};
                if (want_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat kind=%0d value=%0d",
                             $time, got.kind, got.val);
                end else begin
                    want = want_q.pop_front();
                    if (got != want) begin
                        errors++;
                        $display({"%0t: mismatch expected kind=%0d time=%0d value=%0d",
                                  " ceil=%0d idx=%0d last=%0b"},
                                 $time, want.kind, want.tsec, want.val, want.ceil,
                                 want.idx, want.last);
                        $display({"%0t:          actual kind=%0d time=%0d value=%0d",
                                  " ceil=%0d idx=%0d last=%0b"},
                                 $time, got.kind, got.tsec, got.val, got.ceil,
                                 got.idx, got.last);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    dlfp_pkg::RegStartDepth: cfg_depth    = i_cfg_data[11:0];
                    dlfp_pkg::RegStartTemp:  cfg_temp     = i_cfg_data[8:0];
                    dlfp_pkg::RegStartTank:  cfg_tank     = i_cfg_data[14:0];
                    default:                 cfg_interval = i_cfg_data[7:0];
                endcase
            end
            if (i_push && !i_full) parse_byte(i_data_byte, i_start_of_log, i_end_of_log);
        end
        o_errors  <= errors;
        o_pending <= want_q.size();
    end

endmodule

@@ bench/tb_dive_log_four_phase_parser_top.sv @@
// ----------------------------------------------------------------------------
// tb_dive_log_four_phase_parser_top
// Feeds directed and random dive logs through the parser under several
// register settings, with random gaps and stalls on both channels, and
// reports the verdict from the result checker.
// ----------------------------------------------------------------------------
module tb_dive_log_four_phase_parser_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_push;
    logic               o_full;
    logic [7:0]         i_data_byte;
    logic               i_start_of_log;
    logic               i_end_of_log;
    logic               o_empty;
    logic               i_pop;
    logic [3:0]         o_result_kind;
    logic [23:0]        o_time_seconds;
    logic signed [31:0] o_value;
    logic signed [15:0] o_ceiling_feet;
    logic [4:0]         o_event_index;
    logic               o_last_of_run;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [14:0]        i_cfg_data;

    int                 errors;
    int                 pending;
    int                 cycles;
    int                 bytes_sent;
    logic               steady;
    logic               hold_req;
    logic               hold_done;
    int                 hold_left;
    logic [7:0]         log_q[$];

    dive_log_four_phase_parser_top dut (.*);

    dlfp_result_checker u_checker (
        .i_clk, .i_rst_n, .i_push, .i_full(o_full), .i_data_byte, .i_start_of_log,
        .i_end_of_log, .i_empty(o_empty), .i_pop, .i_result_kind(o_result_kind),
        .i_time_seconds(o_time_seconds), .i_value(o_value),
        .i_ceiling_feet(o_ceiling_feet), .i_event_index(o_event_index),
        .i_last_of_run(o_last_of_run), .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (steady || r < 70) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // receiver: random gaps, plus one long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop     <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            i_pop     <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            i_pop     <= 1'b0;
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (!steady && $urandom_range(7) == 0) begin
            i_pop     <= 1'b0;
            hold_left <= gap_len();
        end else begin
            i_pop <= 1'b1;
        end
    end

    task automatic send_byte(logic [7:0] b, logic sol, logic eol);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push         <= 1'b1;
        i_data_byte    <= b;
        i_start_of_log <= sol;
        i_end_of_log   <= eol;
        do @(posedge i_clk); while (o_full);
        bytes_sent++;
    endtask

    task automatic send_log(logic cut);
        int n;
        int cut_at;
        n      = log_q.size();
        cut_at = cut ? $urandom_range(n - 1) : n - 1;
        for (int i = 0; i < n; i++) send_byte(log_q[i], i == 0, i == cut_at);
        log_q.delete();
    endtask

    task automatic drain();
        i_push <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic add_sample();
        int          r;
        logic [7:0]  ev;
        r = $urandom_range(99);
        if (r < 8) begin
            log_q.push_back($urandom_range(1) ? dlfp_pkg::CodeDecoDeeper
                                              : dlfp_pkg::CodeDecoShallow);
            repeat (dlfp_pkg::EventDataBytes) log_q.push_back(8'($urandom));
        end else if (r < 16) begin
            ev = 8'($urandom_range(255, 128));
            if (ev == dlfp_pkg::CodeDecoDeeper || ev == dlfp_pkg::CodeDecoShallow) ev = 8'hA8;
            log_q.push_back(ev);
        end else begin
            log_q.push_back(8'($urandom_range(127)));
            log_q.push_back(8'($urandom));
        end
    endtask

    task automatic random_log();
        logic [7:0] codes[12] = '{8'h00, 8'h01, 8'h02, 8'h03, 8'h10, 8'h06,
                                  8'h0A, 8'h0E, 8'h05, 8'h3F, 8'h7F, 8'h11};
        logic [7:0] c;
        int         recs;
        int         tail;
        recs = $urandom_range(99) < 20 ? $urandom_range(2, 1) : $urandom_range(1) * 3;
        for (int k = 0; k < recs; k++) begin
            c = $urandom_range(3) == 0 ? codes[$urandom_range(11)] : codes[$urandom_range(11, 8)];
            log_q.push_back(c);
            case (c)
                8'h00, 8'h03: tail = 16;
                8'h01, 8'h10: tail = 20;
                8'h02:        tail = 17;
                8'h06, 8'h0A, 8'h0E: tail = 18;
                default:      tail = 0;
            endcase
            repeat (tail) log_q.push_back(8'($urandom));
        end
        if ($urandom_range(1)) log_q.push_back(dlfp_pkg::CodeNotHeader);
        repeat ($urandom_range(20, 4)) add_sample();
        send_log($urandom_range(9) == 0);
    endtask

    task automatic run_phase(int items);
        int stop_at;
        stop_at = bytes_sent + items;
        while (bytes_sent < stop_at) begin
            steady = $urandom_range(5) == 0;
            if ($urandom_range(11) == 0) begin
                repeat ($urandom_range(4, 1))
                    send_byte(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
            end else begin
                random_log();
            end
        end
        steady = 1'b0;
        drain();
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        i_push         <= 1'b0;
        i_data_byte    <= '0;
        i_start_of_log <= 1'b0;
        i_end_of_log   <= 1'b0;
        i_cfg_we       <= 1'b0;
        i_cfg_idx      <= dlfp_pkg::RegStartDepth;
        i_cfg_data     <= '0;
        hold_req       <= 1'b0;
        bytes_sent     = 0;
        steady         = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_byte(8'h05, 1'b1, 1'b1);
        log_q = '{8'h40, 8'h00, 8'hFF, 8'h3F, 8'h80, 8'h7F, 8'h7F, 8'h40, 8'h00,
                  dlfp_pkg::CodeDecoDeeper, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  dlfp_pkg::CodeDecoShallow, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA8,
                  8'hF6, 8'hFF};
        send_log(1'b0);
        drain();

        write_reg(dlfp_pkg::RegStartDepth, 15'd4095);
        write_reg(dlfp_pkg::RegStartTemp, 15'd511);
        write_reg(dlfp_pkg::RegStartTank, 15'd32767);
        write_reg(dlfp_pkg::RegInterval, 15'd255);
        hold_req <= 1'b1;
        run_phase(75);

        write_reg(dlfp_pkg::RegStartDepth, 15'd0);
        write_reg(dlfp_pkg::RegStartTemp, 15'd0);
        write_reg(dlfp_pkg::RegStartTank, 15'd0);
        write_reg(dlfp_pkg::RegInterval, 15'd1);
        run_phase(75);

        write_reg(dlfp_pkg::RegInterval, 15'd0);
        run_phase(30);

        repeat (3) begin
            write_reg(dlfp_pkg::RegStartDepth, 15'($urandom_range(4095)));
            write_reg(dlfp_pkg::RegStartTemp, 15'($urandom_range(511)));
            write_reg(dlfp_pkg::RegStartTank, 15'($urandom_range(32767)));
            write_reg(dlfp_pkg::RegInterval, 15'($urandom_range(255, 1)));
            run_phase(55);
        end

        repeat (20) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
